>>> rtl/lphi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probing hash insert package
// Shared widths, reset values and the result word type.
// ----------------------------------------------------------------------------
package lphi_pkg;

    // Field widths of the input and result words.
    localparam int KEY_W   = 16;
    localparam int SIZE_W  = 11;
    localparam int SLOT_W  = 10;
    localparam int PROBE_W = 11;
    localparam int COUNT_W = 32;

    // Table depth default and the reset value of the size register.
    localparam int                DEPTH_DEFAULT = 1024;
    localparam logic [SIZE_W-1:0] SIZE_RESET    = 11'd1021;

    // Saturation value of the collision counter.
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // One result word.
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [PROBE_W-1:0] probes;
        logic               collided;
        logic               table_full;
        logic [COUNT_W-1:0] collision_total;
    } t_result;

endpackage

>>> rtl/lphi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probing hash insert channels
// Valid/ready channels for the key words and the result words.
// ----------------------------------------------------------------------------
interface lphi_in_if;
    logic                     valid;
    logic                     ready;
    logic [lphi_pkg::KEY_W-1:0] key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

interface lphi_out_if;
    logic                         valid;
    logic                         ready;
    logic [lphi_pkg::SLOT_W-1:0]  slot;
    logic [lphi_pkg::PROBE_W-1:0] probes;
    logic                         collided;
    logic                         table_full;
    logic [lphi_pkg::COUNT_W-1:0] collision_total;

    modport source (output valid, output slot, output probes, output collided,
                    output table_full, output collision_total, input ready);
    modport sink   (input valid, input slot, input probes, input collided,
                    input table_full, input collision_total, output ready);
endinterface

>>> rtl/lphi_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probing hash insert remainder unit
// Restoring remainder of a key by the table size, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lphi_mod_unit #(
    parameter int NW = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lphi_pkg::KEY_W-1:0]  i_dividend,
    input  logic [NW-1:0]               i_divisor,
    output logic                        o_done,
    output logic [NW-1:0]               o_rem
);

    localparam int CW = $clog2(lphi_pkg::KEY_W + 1);

    logic [CW-1:0]              r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [NW-1:0]              r_rem;
    logic [NW-1:0]              r_div;
    logic [lphi_pkg::KEY_W-1:0] r_shift;

    logic [NW:0] w_trial;
    logic        w_fits;

    // One shift and compare-subtract step.
    always_comb begin
        w_trial = {r_rem, r_shift[lphi_pkg::KEY_W-1]};
        w_fits  = w_trial >= {1'b0, r_div};
    end

    // Control: count the key bits down.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(lphi_pkg::KEY_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and remaining key bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_div   <= i_divisor;
            r_shift <= i_dividend;
        end else if (r_busy) begin
            r_rem   <= w_fits ? NW'(w_trial - {1'b0, r_div}) : w_trial[NW-1:0];
            r_shift <= {r_shift[lphi_pkg::KEY_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/lphi_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probing hash insert slot memory
// One write port and one registered read port over the slot store.
// ----------------------------------------------------------------------------
module lphi_table #(
    parameter int DEPTH = lphi_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [lphi_pkg::KEY_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [lphi_pkg::KEY_W-1:0] o_rdata
);

    logic [lphi_pkg::KEY_W-1:0] r_mem [DEPTH];
    logic [lphi_pkg::KEY_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/linear_probing_hash_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probing hash insert
// Per key: the remainder (home slot), the home slot read, the probe steps
// and the result word register, in that order; a full table ends without a write.
// A new key is taken only once its result word is loaded; a stalled result word delays it.
// Reset: a clearing pass writes every slot to empty, during which no key is
// taken; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module linear_probing_hash_insert #(
    parameter int TABLE_DEPTH = lphi_pkg::DEPTH_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lphi_pkg::SIZE_W-1:0]   i_cfg_wdata,
    lphi_in_if.sink                       i_in,
    lphi_out_if.source                    o_out
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = AW + 1;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_DIVIDE = 5'b00100,
        S_PROBE  = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state                          r_state;
    logic [AW-1:0]                   r_clr_addr;
    logic [lphi_pkg::SIZE_W-1:0]     r_size;
    logic [lphi_pkg::KEY_W-1:0]      r_key;
    logic [NW-1:0]                   r_n;
    logic [AW-1:0]                   r_pos;
    logic [NW-1:0]                   r_step;
    logic                            r_collided;
    logic                            r_full;
    logic [lphi_pkg::COUNT_W-1:0]    r_count;
    logic                            r_out_valid;
    lphi_pkg::t_result               r_out;

    logic [31:0]                     w_size32;
    logic [31:0]                     w_n32;
    logic [NW-1:0]                   w_n;
    logic                            w_accept;
    logic                            w_mod_done;
    logic [NW-1:0]                   w_rem;
    logic [lphi_pkg::KEY_W-1:0]      w_rdata;
    logic                            w_empty;
    logic [NW-1:0]                   w_pos_inc;
    logic [AW-1:0]                   w_pos_next;
    logic [NW-1:0]                   w_step_next;
    logic [AW-1:0]                   w_raddr;
    logic                            w_we;
    logic [AW-1:0]                   w_waddr;
    logic [lphi_pkg::KEY_W-1:0]      w_wdata;
    logic                            w_load_out;
    logic [lphi_pkg::COUNT_W-1:0]    w_count_next;
    logic [31:0]                     w_pos32;
    logic [31:0]                     w_step32;

    // Effective table size: the register clamped to 1..TABLE_DEPTH.
    always_comb begin
        w_size32 = 32'(r_size);
        if (w_size32 == 32'd0) begin
            w_n32 = 32'd1;
        end else if (w_size32 > 32'(TABLE_DEPTH)) begin
            w_n32 = 32'(TABLE_DEPTH);
        end else begin
            w_n32 = w_size32;
        end
        w_n = NW'(w_n32);
    end

    assign w_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // Home slot remainder.
    lphi_mod_unit #(.NW(NW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (i_in.key),
        .i_divisor  (w_n),
        .o_done     (w_mod_done),
        .o_rem      (w_rem)
    );

    // Probe step: next slot with wraparound and the probe count.
    always_comb begin
        w_empty     = (w_rdata == '0);
        w_pos_inc   = {1'b0, r_pos} + 1'b1;
        w_pos_next  = (w_pos_inc == r_n) ? '0 : w_pos_inc[AW-1:0];
        w_step_next = r_step + 1'b1;
    end

    // Memory port selection.
    always_comb begin
        w_raddr = r_pos;
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = r_key;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
            end
            S_DIVIDE: begin
                w_raddr = w_rem[AW-1:0];
            end
            S_PROBE: begin
                w_raddr = w_pos_next;
                w_we    = w_empty;
            end
            default: begin
                w_raddr = r_pos;
            end
        endcase
    end

    lphi_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Result word assembly.
    always_comb begin
        w_load_out   = (r_state == S_DONE) && (!r_out_valid || o_out.ready);
        w_count_next = (r_collided && (r_count != lphi_pkg::COUNT_MAX))
                       ? r_count + 1'b1 : r_count;
        w_pos32      = 32'(r_pos);
        w_step32     = 32'(r_step);
    end

    // Sequencer and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_size      <= lphi_pkg::SIZE_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(TABLE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_DIVIDE;
                    end
                end
                S_DIVIDE: begin
                    if (w_mod_done) begin
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (w_empty || (w_step_next == r_n)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load_out) begin
                        r_count <= w_count_next;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Per-item working registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= i_in.key;
            r_n   <= w_n;
        end
        if ((r_state == S_DIVIDE) && w_mod_done) begin
            r_pos  <= w_rem[AW-1:0];
            r_step <= '0;
            r_full <= 1'b0;
        end
        if (r_state == S_PROBE) begin
            if (r_step == '0) begin
                r_collided <= !w_empty;
            end
            if (!w_empty) begin
                r_step <= w_step_next;
                if (w_step_next == r_n) begin
                    r_full <= 1'b1;
                    r_pos  <= '0;
                end else begin
                    r_pos <= w_pos_next;
                end
            end
        end
        if (w_load_out) begin
            r_out.slot            <= w_pos32[lphi_pkg::SLOT_W-1:0];
            r_out.probes          <= w_step32[lphi_pkg::PROBE_W-1:0];
            r_out.collided        <= r_collided;
            r_out.table_full      <= r_full;
            r_out.collision_total <= w_count_next;
        end
    end

    // Output channel.
    assign o_out.valid           = r_out_valid;
    assign o_out.slot            = r_out.slot;
    assign o_out.probes          = r_out.probes;
    assign o_out.collided        = r_out.collided;
    assign o_out.table_full      = r_out.table_full;
    assign o_out.collision_total = r_out.collision_total;

endmodule

>>> rtl/lphi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probing hash insert checker
// Port-level properties of the result words, bound to the top level.
// ----------------------------------------------------------------------------
module lphi_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [lphi_pkg::SLOT_W-1:0]  i_slot,
    input logic [lphi_pkg::PROBE_W-1:0] i_probes,
    input logic                         i_collided,
    input logic                         i_table_full
);

    // A stalled result word holds its place.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_slot)
                                        && $stable(i_probes))
        else $error("result word changed while stalled");

    // A full table means the home slot was occupied.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_table_full |-> i_collided)
        else $error("full table without a collision");

    // A full table reports slot zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_table_full |-> (i_slot == '0))
        else $error("full table with a nonzero slot");

    // An empty home slot takes no probe steps.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_collided |-> (i_probes == '0))
        else $error("probe steps without a collision");

endmodule

bind linear_probing_hash_insert lphi_checker u_lphi_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_slot       (o_out.slot),
    .i_probes     (o_out.probes),
    .i_collided   (o_out.collided),
    .i_table_full (o_out.table_full)
);
